// ===== rtl/ple_pkg.sv =====
// ============================================================================
// ple_pkg
// Types and constants shared by the positional list engine and its parts.
// ============================================================================
package ple_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 8;
   localparam int ACTION_W    = 2;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W       = (POS_W > CNT_W + 1) ? POS_W : CNT_W + 1;
   localparam int REQ_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((VALUE_W + 2 * CNT_W + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_GET    = 2'd2,
      ACT_LOCATE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_GET,
      ST_LOC_RD,
      ST_LOC_CMP,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/ple_ram.sv =====
// ============================================================================
// ple_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/positional_list_engine.sv =====
// ============================================================================
// positional_list_engine
// Ordered list of signed 32-bit words with 1-based insert/delete/get/locate.
// ============================================================================
// Usage:
//   req channel: one word per action. req_tuser = action, req_tdata holds
//   position (low 8 bits) and value. req_tready is high only while idle.
//   rsp channel: one word per action. rsp_tuser = ok, rsp_tdata holds
//   read_value, found_position and count (count after the action).
// Steps per action:
//   rejected action     straight to the response
//   get                 one RAM read
//   insert at p         shift entries count..p up one, then write p
//   delete at p         shift entries p+1..count down one
//   locate              scan from position 1 until a hit or the end
//   Entries live in one RAM with one read and one write port; each shift or
//   scan step is a read followed by a compare or a write.
// A finished word sits in the output register; the engine takes the next
// request while it waits, and holds a new result until the register frees.
// Reset empties the list; stored entries are not cleared.
// ============================================================================
module positional_list_engine
   import ple_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // position, value
   input  logic [ACTION_W-1:0]    req_tuser,  // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // read_value, found_position, count
   output logic [0:0]             rsp_tuser   // ok
);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [ADDR_W-1:0]      pos0_ff, pos0_in;
   logic [VALUE_W-1:0]     val_ff, val_in;
   logic                   res_ok_ff, res_ok_in;
   logic [VALUE_W-1:0]     res_rd_ff, res_rd_in;
   logic [CNT_W-1:0]       res_found_ff, res_found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff;
   logic [VALUE_W-1:0]     rsp_rd_ff;
   logic [CNT_W-1:0]       rsp_found_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   logic                   accept;
   logic                   out_free;
   action_type             req_action;
   logic [POS_W-1:0]       req_pos;
   logic [VALUE_W-1:0]     req_value;
   logic [CMP_W-1:0]       pos_x, cnt_x;
   logic                   pos_in_list, pos_ins_ok;
   logic                   step_down;
   logic [CNT_W-1:0]       step_sum;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr, rd_addr;
   logic [VALUE_W-1:0]     wr_data, rd_data;

   assign req_action = action_type'(req_tuser);
   assign req_pos    = req_tdata[POS_W-1:0];
   assign req_value  = req_tdata[POS_W +: VALUE_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign pos_x       = CMP_W'(req_pos);
   assign cnt_x       = CMP_W'(count_ff);
   assign pos_in_list = (pos_x != '0) && (pos_x <= cnt_x);
   assign pos_ins_ok  = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1))
                        && (cnt_x < CMP_W'(CAPACITY));

   // shared index step: down while opening a gap, up otherwise
   assign step_down = (state_ff == ST_INS_RD) || (state_ff == ST_INS_WR);
   assign step_sum  = step_down ? idx_ff - CNT_W'(1) : idx_ff + CNT_W'(1);

   ple_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_INSERT: state_in = pos_ins_ok ? ST_INS_RD : ST_DONE;
                  ACT_DELETE: state_in = pos_in_list ? ST_DEL_RD : ST_DONE;
                  ACT_GET:    state_in = pos_in_list ? ST_GET : ST_DONE;
                  ACT_LOCATE: state_in = ST_LOC_RD;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_INS_RD:  state_in = (idx_ff > CNT_W'(pos0_ff)) ? ST_INS_WR : ST_DONE;
         ST_INS_WR:  state_in = ST_INS_RD;
         ST_DEL_RD:  state_in = (step_sum < count_ff) ? ST_DEL_WR : ST_DONE;
         ST_DEL_WR:  state_in = ST_DEL_RD;
         ST_GET:     state_in = ST_DONE;
         ST_LOC_RD:  state_in = (idx_ff < count_ff) ? ST_LOC_CMP : ST_DONE;
         ST_LOC_CMP: state_in = (rd_data == val_ff) ? ST_DONE : ST_LOC_RD;
         ST_DONE:    state_in = out_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos0_in      = pos0_ff;
      val_in       = val_ff;
      res_ok_in    = res_ok_ff;
      res_rd_in    = res_rd_ff;
      res_found_in = res_found_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[ADDR_W-1:0];
      wr_data      = rd_data;
      rd_addr      = step_sum[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = ADDR_W'(req_pos - POS_W'(1));
            if (accept) begin
               pos0_in      = ADDR_W'(req_pos - POS_W'(1));
               val_in       = req_value;
               res_ok_in    = 1'b0;
               res_rd_in    = '0;
               res_found_in = '0;
               priority case (req_action)
                  ACT_INSERT: idx_in = count_ff;
                  ACT_DELETE: idx_in = CNT_W'(req_pos - POS_W'(1));
                  default:    idx_in = '0;
               endcase
            end
         end
         ST_INS_RD: begin
            if (idx_ff <= CNT_W'(pos0_ff)) begin
               wr_en     = 1'b1;
               wr_addr   = pos0_ff;
               wr_data   = val_ff;
               count_in  = count_ff + CNT_W'(1);
               res_ok_in = 1'b1;
            end
         end
         ST_INS_WR: begin
            wr_en  = 1'b1;
            idx_in = step_sum;
         end
         ST_DEL_RD: begin
            if (step_sum >= count_ff) begin
               count_in  = count_ff - CNT_W'(1);
               res_ok_in = 1'b1;
            end
         end
         ST_DEL_WR: begin
            wr_en  = 1'b1;
            idx_in = step_sum;
         end
         ST_GET: begin
            res_rd_in = rd_data;
            res_ok_in = 1'b1;
         end
         ST_LOC_RD: begin
            rd_addr = idx_ff[ADDR_W-1:0];
         end
         ST_LOC_CMP: begin
            if (rd_data == val_ff) begin
               res_ok_in    = 1'b1;
               res_found_in = step_sum;
            end else begin
               idx_in = step_sum;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pos0_ff      <= pos0_in;
      val_ff       <= val_in;
      res_ok_ff    <= res_ok_in;
      res_rd_ff    <= res_rd_in;
      res_found_ff <= res_found_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_rd_ff    <= res_rd_ff;
         rsp_found_ff <= res_found_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_count_ff, rsp_found_ff, rsp_rd_ff});

endmodule

// ===== rtl/ple_checker.sv =====
// ============================================================================
// ple_checker
// Port-level checks for the positional list engine, bound to the top level.
// ============================================================================
module ple_checker
   import ple_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [0:0]             rsp_tuser
);

   logic [VALUE_W-1:0] chk_rd;
   logic [CNT_W-1:0]   chk_found;
   logic [CNT_W-1:0]   chk_count;

   assign chk_rd    = rsp_tdata[VALUE_W-1:0];
   assign chk_found = rsp_tdata[VALUE_W +: CNT_W];
   assign chk_count = rsp_tdata[VALUE_W + CNT_W +: CNT_W];

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("engine ready right after accepting a word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> chk_count <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> chk_rd == '0 && chk_found == '0)
      else $error("failed action returned data");

   a_found_in_list: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && chk_found != '0 |-> rsp_tuser[0] && chk_found <= chk_count)
      else $error("found position outside list");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb.sv =====
// ============================================================================
// tb - positional list engine testbench
// Sends insert/delete/get/locate words, mirrors the list in a scoreboard and
// checks every response word field by field against the mirrored list.
// Includes a long receiver hold-off to back up the engine and its input.
// ============================================================================
module tb
   import ple_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 900;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 40;

   typedef struct packed {
      logic                      ok;
      logic signed [VALUE_W-1:0] read_value;
      logic [CNT_W-1:0]          found_position;
      logic [CNT_W-1:0]          count;
   } list_result_type;

   class list_scoreboard;
      logic signed [VALUE_W-1:0] cells [CAPACITY];
      int                        len;
      list_result_type           expected_results [$];
      int                        failures;

      function new();
         len      = 0;
         failures = 0;
      endfunction

      function void flag(string what, longint want, longint got);
         if (failures < 10) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $realtime, what, want, got);
         end
         failures++;
      endfunction

      // apply one accepted action to the mirrored list and queue its response
      function void note_request(action_type act, int pos, logic signed [VALUE_W-1:0] val);
         list_result_type res;
         int              k;
         res = '0;
         case (act)
            ACT_INSERT: begin
               if (pos >= 1 && pos <= len + 1 && len < CAPACITY) begin
                  for (k = len; k >= pos; k--) cells[k] = cells[k-1];
                  cells[pos-1] = val;
                  len++;
                  res.ok = 1'b1;
               end
            end
            ACT_DELETE: begin
               if (pos >= 1 && pos <= len) begin
                  for (k = pos - 1; k + 1 < len; k++) cells[k] = cells[k+1];
                  len--;
                  res.ok = 1'b1;
               end
            end
            ACT_GET: begin
               if (pos >= 1 && pos <= len) begin
                  res.read_value = cells[pos-1];
                  res.ok         = 1'b1;
               end
            end
            default: begin
               for (k = 0; k < len && !res.ok; k++) begin
                  if (cells[k] == val) begin
                     res.found_position = CNT_W'(k + 1);
                     res.ok             = 1'b1;
                  end
               end
            end
         endcase
         res.count = CNT_W'(len);
         expected_results.push_back(res);
      endfunction

      function void check_response(list_result_type got);
         list_result_type want;
         if (expected_results.size() == 0) begin
            flag("unexpected word, count", -1, got.count);
         end else begin
            want = expected_results.pop_front();
            if (got.ok !== want.ok) flag("ok", want.ok, got.ok);
            if (got.read_value !== want.read_value)
               flag("read_value", want.read_value, got.read_value);
            if (got.found_position !== want.found_position)
               flag("found_position", want.found_position, got.found_position);
            if (got.count !== want.count) flag("count", want.count, got.count);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [ACTION_W-1:0]    req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;

   list_scoreboard sb = new();
   bit             steady;
   bit             hold_request;
   int             quiet_cycles;

   positional_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_word(action_type act, int pos, logic signed [VALUE_W-1:0] val);
      if (!steady && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_TDATA_W'({val, pos[POS_W-1:0]});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(act, pos & 8'hFF, val);
   endtask

   // receiver: random backpressure, one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (steady) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(99) >= 33);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response({rsp_tuser[0], rsp_tdata[VALUE_W-1:0],
                            rsp_tdata[VALUE_W+CNT_W-1:VALUE_W],
                            rsp_tdata[VALUE_W+2*CNT_W-1:VALUE_W+CNT_W]});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                        n;
      int                        r;
      int                        pos;
      int                        phase;
      int                        ins_w;
      int                        del_w;
      int                        get_w;
      int                        small_val;
      action_type                act;
      logic signed [VALUE_W-1:0] val;

      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= ACT_INSERT;
      steady       = 1'b0;
      hold_request = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty list, bad positions, ends, duplicates, extremes
      send_word(ACT_GET,    1,   32'sd0);
      send_word(ACT_DELETE, 1,   32'sd0);
      send_word(ACT_LOCATE, 0,   32'sd0);
      send_word(ACT_INSERT, 0,   32'sd7);
      send_word(ACT_INSERT, 2,   32'sd7);
      send_word(ACT_INSERT, 1,   32'h7FFF_FFFF);
      send_word(ACT_INSERT, 1,   32'h8000_0000);
      send_word(ACT_INSERT, 3,   -32'sd1);
      send_word(ACT_INSERT, 255, 32'sd5);
      send_word(ACT_INSERT, 2,   32'sd0);
      send_word(ACT_INSERT, 5,   32'sd0);
      send_word(ACT_LOCATE, 255, 32'sd0);
      send_word(ACT_LOCATE, 0,   -32'sd1);
      send_word(ACT_LOCATE, 0,   32'h8000_0000);
      send_word(ACT_LOCATE, 0,   32'sd12345);
      send_word(ACT_GET,    1,   32'sd0);
      send_word(ACT_GET,    5,   32'hFFFF_FFFF);
      send_word(ACT_GET,    6,   32'sd0);
      send_word(ACT_GET,    0,   32'sd0);
      send_word(ACT_GET,    255, 32'sd0);
      send_word(ACT_DELETE, 5,   32'sd0);
      send_word(ACT_DELETE, 1,   32'sd0);
      send_word(ACT_DELETE, 255, 32'sd0);
      send_word(ACT_DELETE, 0,   32'sd0);

      // grow / mixed / shrink phases so the list fills up and drains
      for (n = 0; n < RANDOM_WORDS; n++) begin
         steady = (n >= 300 && n < 450);
         if (n == 600) hold_request = 1'b1;
         phase = (n / 150) % 3;
         case (phase)
            0:       begin ins_w = 60; del_w = 75; get_w = 88; end
            1:       begin ins_w = 35; del_w = 65; get_w = 83; end
            default: begin ins_w = 15; del_w = 75; get_w = 88; end
         endcase
         r = $urandom_range(99);
         if (r < ins_w)      act = ACT_INSERT;
         else if (r < del_w) act = ACT_DELETE;
         else if (r < get_w) act = ACT_GET;
         else                act = ACT_LOCATE;

         if ($urandom_range(99) < 15 || act == ACT_LOCATE) begin
            pos = $urandom_range(0, 255);
         end else if (act == ACT_INSERT) begin
            pos = $urandom_range(1, sb.len + 1);
         end else if (sb.len > 0) begin
            pos = $urandom_range(1, sb.len);
         end else begin
            pos = $urandom_range(0, 3);
         end

         r = $urandom_range(99);
         if (act == ACT_LOCATE && sb.len > 0 && r < 60) begin
            val = sb.cells[$urandom_range(0, sb.len - 1)];
         end else if (r < 35) begin
            small_val = $urandom_range(0, 6);
            val       = small_val - 3;
         end else begin
            val = $urandom;
         end
         send_word(act, pos, val);
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
